@@ rtl/zbpa_pkg.sv @@
// Shared types, codes and helper functions for the zone box property averager.
`timescale 1ns / 1ps
`default_nettype none
package zbpa_pkg;

    typedef enum logic [1:0] {
        OP_SAMPLE   = 2'd0,
        OP_STEP     = 2'd1,
        OP_STEP_OUT = 2'd2,
        OP_LOAD     = 2'd3
    } opcode_t;

    localparam logic [1:0] REG_BOX_COUNT = 2'd0;
    localparam logic [1:0] REG_ID_MASK   = 2'd1;
    localparam logic [1:0] REG_INV_AREA  = 2'd2;
    localparam logic [1:0] REG_CLEAR     = 2'd3;

    // accumulator file slots
    localparam logic [2:0] ACC_MASS   = 3'd0;
    localparam logic [2:0] ACC_MOM_X  = 3'd1;
    localparam logic [2:0] ACC_MOM_Y  = 3'd2;
    localparam logic [2:0] ACC_MOM_Z  = 3'd3;
    localparam logic [2:0] ACC_VEL_X  = 3'd4;
    localparam logic [2:0] ACC_VEL_Y  = 3'd5;
    localparam logic [2:0] ACC_VEL_Z  = 3'd6;
    localparam logic [2:0] ACC_ENERGY = 3'd7;

    localparam logic [47:0] CNT_MAX  = 48'hFFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SUM_MIN  = 64'h8000_0000_0000_0000;
    localparam logic [31:0] STEP_MAX = 32'hFFFF_FFFF;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    // accumulator slot feeding each quotient (quotient 0 is the count)
    function automatic logic [2:0] div_src(input logic [3:0] k);
        logic [2:0] s;
        begin
            case (k)
                4'd1:    s = ACC_MASS;
                4'd2:    s = ACC_VEL_X;
                4'd3:    s = ACC_VEL_Y;
                4'd4:    s = ACC_VEL_Z;
                4'd5:    s = ACC_ENERGY;
                4'd6:    s = ACC_MOM_X;
                4'd7:    s = ACC_MOM_Y;
                4'd8:    s = ACC_MOM_Z;
                default: s = ACC_MASS;
            endcase
            return s;
        end
    endfunction

    // combine the two 64-bit partial products of a Q16.16 scale, saturate
    function automatic logic [63:0] scale_join(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] r;
        begin
            r = {hi[47:0], 16'b0} + {16'b0, lo[63:16]};
            if (hi[63:47] != 17'b0 || r[63])
                r = SUM_MAX;
            return r;
        end
    endfunction

endpackage
`default_nettype wire

@@ rtl/zbpa_if.sv @@
// Valid/ready channel interfaces for input items and result items.
`timescale 1ns / 1ps
`default_nettype none
interface zbpa_in_if;
    logic               valid;
    logic               ready;
    logic        [1:0]  opcode;
    logic        [5:0]  agent_id;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic        [31:0] agent_mass;
    logic        [2:0]  box_index;
    logic               corner_select;

    modport source (output valid, opcode, agent_id, pos_x, pos_y, pos_z, vel_x, vel_y,
                    vel_z, agent_mass, box_index, corner_select, input ready);
    modport sink   (input valid, opcode, agent_id, pos_x, pos_y, pos_z, vel_x, vel_y,
                    vel_z, agent_mass, box_index, corner_select, output ready);
endinterface

interface zbpa_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] avg_count;
    logic signed [63:0] number_density;
    logic signed [63:0] mass_density;
    logic signed [63:0] avg_vel_x;
    logic signed [63:0] avg_vel_y;
    logic signed [63:0] avg_vel_z;
    logic signed [63:0] avg_energy;
    logic signed [63:0] avg_mom_x;
    logic signed [63:0] avg_mom_y;
    logic signed [63:0] avg_mom_z;
    logic               overflow_flag;

    modport source (output valid, avg_count, number_density, mass_density, avg_vel_x,
                    avg_vel_y, avg_vel_z, avg_energy, avg_mom_x, avg_mom_y, avg_mom_z,
                    overflow_flag, input ready);
    modport sink   (input valid, avg_count, number_density, mass_density, avg_vel_x,
                    avg_vel_y, avg_vel_z, avg_energy, avg_mom_x, avg_mom_y, avg_mom_z,
                    overflow_flag, output ready);
endinterface
`default_nettype wire

@@ rtl/zone_box_property_averager.sv @@
// Top level: sequencer, box table, accumulators and output register.
// Box-bound averager. A sample whose id is selected first runs its six
// products through the one shared multiplier, then for each box in use reads
// and tests both corners from the box table (one read port) in S_RD_LO,
// S_RD_HI and S_CHK; for each box that contains it, the shared saturating
// adder then updates the eight sums one after another. An output tick runs
// nine divisions on the shared divider and four scale products. The block
// takes no item while a sample or an output tick is in work. Box corners
// that were never loaded read as garbage.
`timescale 1ns / 1ps
`default_nettype none
module zone_box_property_averager
    import zbpa_pkg::*;
#(
    parameter int MAX_BOXES = 8,
    parameter int ID_RANGE  = 64
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_wdata,
    zbpa_in_if.sink          item,
    zbpa_out_if.source       result
);

    localparam int RW = $clog2(2 * MAX_BOXES) < 1 ? 1 : $clog2(2 * MAX_BOXES);
    localparam int BW = $clog2(MAX_BOXES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL, S_RD_LO, S_RD_HI, S_CHK, S_ACC,
        S_DIV_GO, S_DIV_WAIT, S_SCALE, S_FIN
    } state_t;

    state_t             state_reg;
    logic [3:0]         box_count_reg;
    logic [ID_RANGE-1:0] id_mask_reg;
    logic [31:0]        inv_area_reg;
    logic               clear_reg;

    logic [95:0]        box_mem [2 * MAX_BOXES];
    logic [95:0]        mem_q;
    logic [RW-1:0]      rd_addr;

    logic signed [31:0] pos_reg [3];
    logic signed [31:0] vel_reg [3];
    logic [31:0]        mass_reg;
    logic [63:0]        mom_reg [3];
    logic [63:0]        sq_reg;
    logic [2:0]         mcnt_reg;
    logic [2:0]         acnt_reg;
    logic [3:0]         dk_reg;
    logic [BW-1:0]      box_reg;
    logic               ge_reg;

    logic [47:0]        count_reg;
    logic [63:0]        acc_reg [8];
    logic [31:0]        step_reg;
    logic               sat_reg;
    logic [63:0]        res_reg [9];
    logic [63:0]        sc_reg [4];

    logic               out_valid_reg;
    logic [63:0]        out_reg [10];
    logic               out_ovf_reg;

    logic               accept;
    logic               selected;
    logic [63:0]        mask_ext;
    logic [BW-1:0]      nb;
    logic [31:0]        mul_a;
    logic [31:0]        mul_b;
    logic [63:0]        mul_p;
    logic [2:0]         mk;
    logic [63:0]        addend;
    logic [63:0]        acc_cur;
    logic [63:0]        add_s;
    logic               add_ovf;
    logic [63:0]        add_r;
    logic [63:0]        div_src_val;
    logic               div_neg;
    logic [63:0]        qs;
    logic               lo_ok;
    logic               hi_ok;
    logic               out_load;
    div_req_t           dreq;
    div_rsp_t           drsp;

    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        begin
            return v[31] ? 32'(-v) : 32'(v);
        end
    endfunction

    assign accept   = item.valid && item.ready;
    assign mask_ext = 64'(id_mask_reg);
    assign selected = mask_ext[item.agent_id];
    assign nb       = (int'(box_count_reg) > MAX_BOXES) ? BW'(MAX_BOXES) : BW'(box_count_reg);
    assign mk       = mcnt_reg - 3'd1;
    assign out_load = (state_reg == S_FIN) && (!out_valid_reg || result.ready);

    // shared multiplier operands
    always_comb
    begin
        mul_a = 32'd0;
        mul_b = 32'd0;
        if (state_reg == S_MUL)
        begin
            case (mcnt_reg)
                3'd0:    begin mul_a = mag32(vel_reg[0]); mul_b = mass_reg; end
                3'd1:    begin mul_a = mag32(vel_reg[1]); mul_b = mass_reg; end
                3'd2:    begin mul_a = mag32(vel_reg[2]); mul_b = mass_reg; end
                3'd3:    begin mul_a = mag32(vel_reg[0]); mul_b = mag32(vel_reg[0]); end
                3'd4:    begin mul_a = mag32(vel_reg[1]); mul_b = mag32(vel_reg[1]); end
                3'd5:    begin mul_a = mag32(vel_reg[2]); mul_b = mag32(vel_reg[2]); end
                default: begin mul_a = 32'd0; mul_b = 32'd0; end
            endcase
        end
        else if (state_reg == S_SCALE)
        begin
            case (mcnt_reg)
                3'd0:    begin mul_a = res_reg[0][31:0];  mul_b = inv_area_reg; end
                3'd1:    begin mul_a = res_reg[0][63:32]; mul_b = inv_area_reg; end
                3'd2:    begin mul_a = res_reg[1][31:0];  mul_b = inv_area_reg; end
                3'd3:    begin mul_a = res_reg[1][63:32]; mul_b = inv_area_reg; end
                default: begin mul_a = 32'd0; mul_b = 32'd0; end
            endcase
        end
    end

    zbpa_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

    // shared saturating adder
    always_comb
    begin
        case (acnt_reg)
            ACC_MASS:   addend = {32'b0, mass_reg};
            ACC_MOM_X:  addend = mom_reg[0];
            ACC_MOM_Y:  addend = mom_reg[1];
            ACC_MOM_Z:  addend = mom_reg[2];
            ACC_VEL_X:  addend = 64'(vel_reg[0]);
            ACC_VEL_Y:  addend = 64'(vel_reg[1]);
            ACC_VEL_Z:  addend = 64'(vel_reg[2]);
            ACC_ENERGY: addend = {17'b0, sq_reg[63:17]};
            default:    addend = 64'd0;
        endcase
        acc_cur = acc_reg[acnt_reg];
        add_s   = acc_cur + addend;
        add_ovf = (acc_cur[63] == addend[63]) && (add_s[63] != acc_cur[63]);
        add_r   = add_ovf ? (acc_cur[63] ? SUM_MIN : SUM_MAX) : add_s;
    end

    // divider feed
    always_comb
    begin
        div_src_val = (dk_reg == 4'd0) ? {count_reg, 16'b0} : acc_reg[div_src(dk_reg)];
        div_neg     = (dk_reg != 4'd0) && div_src_val[63];
        dreq.start    = (state_reg == S_DIV_GO);
        dreq.dividend = div_neg ? 64'(-div_src_val) : div_src_val;
        dreq.divisor  = step_reg;
        qs = div_neg ? 64'(-drsp.quotient) : drsp.quotient;
        if (dk_reg == 4'd0 && drsp.quotient[63])
            qs = SUM_MAX;
    end

    zbpa_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

    // box table
    assign rd_addr = RW'({box_reg, state_reg == S_RD_HI});

    always_ff @(posedge clk)
    begin
        if (accept && item.opcode == OP_LOAD && int'(item.box_index) < MAX_BOXES)
            box_mem[RW'({5'b0, item.box_index, item.corner_select})] <=
                {item.pos_z, item.pos_y, item.pos_x};
        mem_q <= box_mem[rd_addr];
    end

    always_comb
    begin
        lo_ok = 1'b1;
        hi_ok = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if (pos_reg[a] < $signed(mem_q[32*a +: 32]))
                lo_ok = 1'b0;
            if (pos_reg[a] > $signed(mem_q[32*a +: 32]))
                hi_ok = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            box_count_reg <= 4'd0;
            id_mask_reg   <= '0;
            inv_area_reg  <= 32'd65536;
            clear_reg     <= 1'b1;
            count_reg     <= 48'd0;
            step_reg      <= 32'd0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_ovf_reg   <= 1'b0;
            mcnt_reg      <= 3'd0;
            acnt_reg      <= 3'd0;
            dk_reg        <= 4'd0;
            box_reg       <= '0;
            ge_reg        <= 1'b0;
            mass_reg      <= 32'd0;
            sq_reg        <= 64'd0;
            for (int i = 0; i < 8; i++)
                acc_reg[i] <= 64'd0;
            for (int i = 0; i < 3; i++)
            begin
                pos_reg[i] <= 32'sd0;
                vel_reg[i] <= 32'sd0;
                mom_reg[i] <= 64'd0;
            end
            for (int i = 0; i < 9; i++)
                res_reg[i] <= 64'd0;
            for (int i = 0; i < 4; i++)
                sc_reg[i] <= 64'd0;
            for (int i = 0; i < 10; i++)
                out_reg[i] <= 64'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_BOX_COUNT: box_count_reg <= cfg_wdata[3:0];
                    REG_ID_MASK:   id_mask_reg   <= cfg_wdata[ID_RANGE-1:0];
                    REG_INV_AREA:  inv_area_reg  <= cfg_wdata[31:0];
                    REG_CLEAR:     clear_reg     <= cfg_wdata[0];
                    default:       ;
                endcase
            end

            // drop the beat once taken, unless a new one loads at the same edge
            if (out_valid_reg && result.ready && !out_load)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        pos_reg[0] <= item.pos_x;
                        pos_reg[1] <= item.pos_y;
                        pos_reg[2] <= item.pos_z;
                        vel_reg[0] <= item.vel_x;
                        vel_reg[1] <= item.vel_y;
                        vel_reg[2] <= item.vel_z;
                        mass_reg   <= item.agent_mass;
                        sq_reg     <= 64'd0;
                        mcnt_reg   <= 3'd0;
                        dk_reg     <= 4'd0;
                        case (item.opcode)
                            OP_SAMPLE:
                            begin
                                if (selected)
                                    state_reg <= S_MUL;
                            end
                            OP_STEP, OP_STEP_OUT:
                            begin
                                if (step_reg == STEP_MAX)
                                    sat_reg <= 1'b1;
                                else
                                    step_reg <= step_reg + 32'd1;
                                if (item.opcode == OP_STEP_OUT)
                                    state_reg <= S_DIV_GO;
                            end
                            default: ;
                        endcase
                    end
                end

                S_MUL:
                begin
                    // capture the product issued on the previous cycle
                    if (mcnt_reg != 3'd0)
                    begin
                        if (mk < 3'd3)
                            mom_reg[mk[1:0]] <= vel_reg[mk[1:0]][31]
                                ? 64'(-{16'b0, mul_p[63:16]}) : {16'b0, mul_p[63:16]};
                        else
                            sq_reg <= sq_reg + mul_p;
                    end
                    mcnt_reg <= mcnt_reg + 3'd1;
                    if (mcnt_reg == 3'd6)
                    begin
                        box_reg   <= '0;
                        state_reg <= (nb == '0) ? S_IDLE : S_RD_LO;
                    end
                end

                S_RD_LO: state_reg <= S_RD_HI;

                S_RD_HI:
                begin
                    ge_reg    <= lo_ok;
                    state_reg <= S_CHK;
                end

                S_CHK:
                begin
                    if (ge_reg && hi_ok)
                    begin
                        if (count_reg == CNT_MAX)
                            sat_reg <= 1'b1;
                        else
                            count_reg <= count_reg + 48'd1;
                        acnt_reg  <= 3'd0;
                        state_reg <= S_ACC;
                    end
                    else if (BW'(box_reg + 1'b1) == nb)
                        state_reg <= S_IDLE;
                    else
                    begin
                        box_reg   <= BW'(box_reg + 1'b1);
                        state_reg <= S_RD_LO;
                    end
                end

                S_ACC:
                begin
                    acc_reg[acnt_reg] <= add_r;
                    if (add_ovf)
                        sat_reg <= 1'b1;
                    acnt_reg <= acnt_reg + 3'd1;
                    if (acnt_reg == ACC_ENERGY)
                    begin
                        if (BW'(box_reg + 1'b1) == nb)
                            state_reg <= S_IDLE;
                        else
                        begin
                            box_reg   <= BW'(box_reg + 1'b1);
                            state_reg <= S_RD_LO;
                        end
                    end
                end

                S_DIV_GO: state_reg <= S_DIV_WAIT;

                S_DIV_WAIT:
                begin
                    if (drsp.done)
                    begin
                        res_reg[dk_reg] <= qs;
                        if (dk_reg == 4'd8)
                        begin
                            mcnt_reg  <= 3'd0;
                            state_reg <= S_SCALE;
                        end
                        else
                        begin
                            dk_reg    <= dk_reg + 4'd1;
                            state_reg <= S_DIV_GO;
                        end
                    end
                end

                S_SCALE:
                begin
                    if (mcnt_reg != 3'd0)
                        sc_reg[mk[1:0]] <= mul_p;
                    mcnt_reg <= mcnt_reg + 3'd1;
                    if (mcnt_reg == 3'd4)
                        state_reg <= S_FIN;
                end

                S_FIN:
                begin
                    // hold until the output register is free
                    if (out_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_reg[0]    <= res_reg[0];
                        out_reg[1]    <= scale_join(sc_reg[0], sc_reg[1]);
                        out_reg[2]    <= scale_join(sc_reg[2], sc_reg[3]);
                        out_reg[3]    <= res_reg[2];
                        out_reg[4]    <= res_reg[3];
                        out_reg[5]    <= res_reg[4];
                        out_reg[6]    <= res_reg[5];
                        out_reg[7]    <= res_reg[6];
                        out_reg[8]    <= res_reg[7];
                        out_reg[9]    <= res_reg[8];
                        out_ovf_reg   <= sat_reg;
                        if (clear_reg)
                        begin
                            count_reg <= 48'd0;
                            step_reg  <= 32'd0;
                            sat_reg   <= 1'b0;
                            for (int i = 0; i < 8; i++)
                                acc_reg[i] <= 64'd0;
                        end
                        state_reg <= S_IDLE;
                    end
                end

                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign item.ready            = (state_reg == S_IDLE);
    assign result.valid          = out_valid_reg;
    assign result.avg_count      = out_reg[0];
    assign result.number_density = out_reg[1];
    assign result.mass_density   = out_reg[2];
    assign result.avg_vel_x      = out_reg[3];
    assign result.avg_vel_y      = out_reg[4];
    assign result.avg_vel_z      = out_reg[5];
    assign result.avg_energy     = out_reg[6];
    assign result.avg_mom_x      = out_reg[7];
    assign result.avg_mom_y      = out_reg[8];
    assign result.avg_mom_z      = out_reg[9];
    assign result.overflow_flag  = out_ovf_reg;

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |-> (!out_valid_reg || result.ready))
        else $error("result register loaded while a beat is pending");

    a_clear_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && clear_reg) |=> (step_reg == 32'd0 && count_reg == 48'd0))
        else $error("sums not cleared after output");

    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        item.ready |-> !drsp.busy)
        else $error("divider busy while taking items");

endmodule
`default_nettype wire

@@ rtl/zbpa_mul.sv @@
// Shared 32x32 unsigned multiplier with registered product.
`timescale 1ns / 1ps
`default_nettype none
module zbpa_mul
(
    input  wire logic        clk,
    input  wire logic [31:0] a,
    input  wire logic [31:0] b,
    output logic      [63:0] p
);

    logic [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= {32'b0, a} * {32'b0, b};
    end

    assign p = p_reg;

endmodule
`default_nettype wire

@@ rtl/zbpa_div.sv @@
// Restoring divider, 64-bit dividend by 32-bit divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module zbpa_div
    import zbpa_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire div_req_t req,
    output div_rsp_t      rsp
);

    logic [63:0] q_reg;
    logic [31:0] rem_reg;
    logic [31:0] dsr_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;
    logic        ge;

    assign trial = {rem_reg, q_reg[63]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
            q_reg    <= 64'd0;
            rem_reg  <= 32'd0;
            dsr_reg  <= 32'd0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                q_reg    <= req.dividend;
                dsr_reg  <= req.divisor;
                rem_reg  <= 32'd0;
                cnt_reg  <= 7'd64;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                rem_reg <= ge ? 32'(trial - {1'b0, dsr_reg}) : trial[31:0];
                q_reg   <= {q_reg[62:0], ge};
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = q_reg;

endmodule
`default_nettype wire

@@ tb/sv/zone_box_property_averager_test.sv @@
// Self-checking testbench for the zone box property averager.
`timescale 1ns / 1ps
`default_nettype none
module zone_box_property_averager_test;
    import zbpa_pkg::*;

    typedef struct packed {
        opcode_t            op;
        logic        [5:0]  id;
        logic signed [31:0] px, py, pz, vx, vy, vz;
        logic        [31:0] mass;
        logic        [2:0]  bidx;
        logic               corner;
    } sample_beat_t;

    typedef struct packed {
        logic [9:0][63:0] val;
        logic             flag;
    } average_t;

    localparam int    NBOX       = 8;
    localparam int    IDLE_LIMIT = 20000;
    localparam int    DRAIN_WAIT = 700;
    localparam longint SMAX      = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint SMIN      = 64'sh8000_0000_0000_0000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_wdata;

    zbpa_in_if  item_ch ();
    zbpa_out_if result_ch ();

    zone_box_property_averager u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .item      (item_ch),
        .result    (result_ch)
    );

    // predicted block state
    int          corner_lo [NBOX][3];
    int          corner_hi [NBOX][3];
    logic [47:0] cnt_sum;
    longint      acc_mass, acc_energy;
    longint      acc_mom [3];
    longint      acc_vel [3];
    logic [31:0] steps;
    logic        sat_seen;
    logic [3:0]  r_box_count;
    logic [63:0] r_id_mask;
    logic [31:0] r_inv_area;
    logic        r_clear;

    // generator's view of the box table
    int gen_lo [NBOX][3];
    int gen_hi [NBOX][3];

    sample_beat_t pending[$];
    average_t     averages_due[$];

    int  errors, src_gap, sink_gap, hold_cnt, idle_cycles;
    int  n_items, n_results, n_hits;
    bit  quiet, hold_go, hold_done, beat_in;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint acc_add(input longint a, input longint b);
        logic signed [64:0] s;
        s = $signed({a[63], a}) + $signed({b[63], b});
        if (s > $signed({1'b0, SMAX}))
        begin
            sat_seen = 1'b1;
            return SMAX;
        end
        if (s < $signed({1'b1, SMIN}))
        begin
            sat_seen = 1'b1;
            return SMIN;
        end
        return s[63:0];
    endfunction

    function automatic logic [63:0] quot(input longint s, input logic [31:0] d);
        logic [63:0] mag, q;
        mag = s[63] ? 64'd0 - s : s;
        q   = mag / {32'd0, d};
        return s[63] ? 64'd0 - q : q;
    endfunction

    function automatic logic [63:0] area_scale(input logic [63:0] a, input logic [31:0] b);
        logic [63:0] lo, hi, r;
        lo = {32'd0, a[31:0]} * {32'd0, b};
        hi = {32'd0, a[63:32]} * {32'd0, b};
        if (hi[63:47] != 0)
            return SMAX;
        r = (hi << 16) + (lo >> 16);
        if (r[63])
            return SMAX;
        return r;
    endfunction

    function automatic void clear_sums();
        cnt_sum    = '0;
        acc_mass   = 0;
        acc_energy = 0;
        for (int a = 0; a < 3; a++)
        begin
            acc_mom[a] = 0;
            acc_vel[a] = 0;
        end
        steps    = '0;
        sat_seen = 1'b0;
    endfunction

    // advance the state by one beat; return 1 with the averages on an output tick
    function automatic bit track_beat(input sample_beat_t b, output average_t res);
        longint      pos [3];
        longint      vel [3];
        longint      mom [3];
        logic [63:0] mag, sq, avg_n, avg_m;
        longint      ke;
        int          nb;
        bit          hit;
        res = '0;
        pos[0] = b.px; pos[1] = b.py; pos[2] = b.pz;
        vel[0] = b.vx; vel[1] = b.vy; vel[2] = b.vz;
        case (b.op)
            OP_LOAD:
            begin
                for (int a = 0; a < 3; a++)
                    if (b.corner)
                        corner_hi[b.bidx][a] = int'(pos[a]);
                    else
                        corner_lo[b.bidx][a] = int'(pos[a]);
                return 0;
            end
            OP_SAMPLE:
            begin
                if (!r_id_mask[b.id])
                    return 0;
                sq = '0;
                for (int a = 0; a < 3; a++)
                begin
                    mag = vel[a] < 0 ? -vel[a] : vel[a];
                    sq  = sq + mag * mag;
                    mag = (mag * {32'd0, b.mass}) >> 16;
                    mom[a] = vel[a] < 0 ? -longint'(mag) : longint'(mag);
                end
                ke = longint'(sq >> 17);
                nb = r_box_count > NBOX ? NBOX : r_box_count;
                for (int k = 0; k < nb; k++)
                begin
                    hit = 1;
                    for (int a = 0; a < 3; a++)
                        if (pos[a] < corner_lo[k][a] || pos[a] > corner_hi[k][a])
                            hit = 0;
                    if (!hit)
                        continue;
                    n_hits++;
                    if (cnt_sum == CNT_MAX)
                        sat_seen = 1'b1;
                    else
                        cnt_sum++;
                    acc_mass = acc_add(acc_mass, longint'({32'd0, b.mass}));
                    for (int a = 0; a < 3; a++)
                    begin
                        acc_mom[a] = acc_add(acc_mom[a], mom[a]);
                        acc_vel[a] = acc_add(acc_vel[a], vel[a]);
                    end
                    acc_energy = acc_add(acc_energy, ke);
                end
                return 0;
            end
            default:
            begin
                if (steps == STEP_MAX)
                    sat_seen = 1'b1;
                else
                    steps++;
                if (b.op == OP_STEP)
                    return 0;
                avg_n = {cnt_sum, 16'd0} / {32'd0, steps};
                if (avg_n[63])
                    avg_n = SMAX;
                avg_m = quot(acc_mass, steps);
                res.val[0] = avg_n;
                res.val[1] = area_scale(avg_n, r_inv_area);
                res.val[2] = area_scale(avg_m, r_inv_area);
                for (int a = 0; a < 3; a++)
                begin
                    res.val[3 + a] = quot(acc_vel[a], steps);
                    res.val[7 + a] = quot(acc_mom[a], steps);
                end
                res.val[6] = quot(acc_energy, steps);
                res.flag   = sat_seen;
                if (r_clear)
                    clear_sums();
                return 1;
            end
        endcase
    endfunction

    // input side: sample accepted beats and predict
    always @(posedge clk)
    begin
        sample_beat_t b;
        average_t     res;
        beat_in <= item_ch.valid && item_ch.ready;
        if (rst_n && item_ch.valid && item_ch.ready)
        begin
            b.op     = opcode_t'(item_ch.opcode);
            b.id     = item_ch.agent_id;
            b.px     = item_ch.pos_x;
            b.py     = item_ch.pos_y;
            b.pz     = item_ch.pos_z;
            b.vx     = item_ch.vel_x;
            b.vy     = item_ch.vel_y;
            b.vz     = item_ch.vel_z;
            b.mass   = item_ch.agent_mass;
            b.bidx   = item_ch.box_index;
            b.corner = item_ch.corner_select;
            n_items++;
            if (track_beat(b, res))
                averages_due.push_back(res);
        end
    end

    // result side: compare each beat with the oldest prediction
    always @(posedge clk)
    begin
        average_t got, want;
        string    names [10];
        names = '{"avg_count", "number_density", "mass_density", "avg_vel_x", "avg_vel_y",
                  "avg_vel_z", "avg_energy", "avg_mom_x", "avg_mom_y", "avg_mom_z"};
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got.val[0] = result_ch.avg_count;
            got.val[1] = result_ch.number_density;
            got.val[2] = result_ch.mass_density;
            got.val[3] = result_ch.avg_vel_x;
            got.val[4] = result_ch.avg_vel_y;
            got.val[5] = result_ch.avg_vel_z;
            got.val[6] = result_ch.avg_energy;
            got.val[7] = result_ch.avg_mom_x;
            got.val[8] = result_ch.avg_mom_y;
            got.val[9] = result_ch.avg_mom_z;
            got.flag   = result_ch.overflow_flag;
            n_results++;
            if (averages_due.size() == 0)
            begin
                $display("%0t unexpected result beat: avg_count %h", $time, got.val[0]);
                errors++;
            end
            else
            begin
                want = averages_due.pop_front();
                for (int k = 0; k < 10; k++)
                    if (got.val[k] !== want.val[k])
                    begin
                        $display("%0t %s expected %h actual %h", $time, names[k],
                                 want.val[k], got.val[k]);
                        errors++;
                    end
                if (got.flag !== want.flag)
                begin
                    $display("%0t overflow_flag expected %b actual %b", $time,
                             want.flag, got.flag);
                    errors++;
                end
            end
        end
    end

    // driver: present the next pending beat, with random gaps
    always @(negedge clk)
    begin
        sample_beat_t b;
        if (rst_n && (!item_ch.valid || beat_in))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                item_ch.valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                b = pending.pop_front();
                item_ch.opcode        <= b.op;
                item_ch.agent_id      <= b.id;
                item_ch.pos_x         <= b.px;
                item_ch.pos_y         <= b.py;
                item_ch.pos_z         <= b.pz;
                item_ch.vel_x         <= b.vx;
                item_ch.vel_y         <= b.vy;
                item_ch.vel_z         <= b.vz;
                item_ch.agent_mass    <= b.mass;
                item_ch.box_index     <= b.bidx;
                item_ch.corner_select <= b.corner;
                item_ch.valid         <= 1'b1;
                if (!quiet && $urandom_range(0, 4) == 0)
                    src_gap = $urandom_range(1, 14);
            end
            else
                item_ch.valid <= 1'b0;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (hold_go && !hold_done)
            begin
                hold_cnt  = 2500;
                hold_done = 1;
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                result_ch.ready <= 1'b0;
            end
            else if (!quiet && sink_gap > 0)
            begin
                sink_gap--;
                result_ch.ready <= 1'b0;
            end
            else
            begin
                result_ch.ready <= 1'b1;
                if (!quiet && $urandom_range(0, 9) == 0)
                    sink_gap = $urandom_range(1, 14);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t watchdog: no beat for %0d cycles", $time, idle_cycles);
            $display("zone_box_property_averager_test: done, errors");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        case (idx)
            REG_BOX_COUNT: r_box_count = data[3:0];
            REG_ID_MASK:   r_id_mask   = data;
            REG_INV_AREA:  r_inv_area  = data[31:0];
            default:       r_clear     = data[0];
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_regs(input logic [3:0] bc, input logic [63:0] mask,
                            input logic [31:0] inv, input logic clr);
        write_reg(REG_BOX_COUNT, {60'd0, bc});
        write_reg(REG_ID_MASK, mask);
        write_reg(REG_INV_AREA, {32'd0, inv});
        write_reg(REG_CLEAR, {63'd0, clr});
    endtask

    task automatic drain();
        while (pending.size() > 0 || item_ch.valid || averages_due.size() > 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic push_load(input int k, input bit c, input int x, input int y, input int z);
        sample_beat_t b;
        b = '0;
        b.op = OP_LOAD; b.bidx = 3'(k); b.corner = c;
        b.px = x; b.py = y; b.pz = z;
        b.id = 6'($urandom); b.mass = $urandom; b.vx = $urandom;
        if (c)
        begin
            gen_hi[k][0] = x; gen_hi[k][1] = y; gen_hi[k][2] = z;
        end
        else
        begin
            gen_lo[k][0] = x; gen_lo[k][1] = y; gen_lo[k][2] = z;
        end
        pending.push_back(b);
    endtask

    task automatic push_sample(input logic [5:0] id, input int x, input int y, input int z,
                               input int vx, input int vy, input int vz,
                               input logic [31:0] m);
        sample_beat_t b;
        b = '0;
        b.op = OP_SAMPLE; b.id = id; b.px = x; b.py = y; b.pz = z;
        b.vx = vx; b.vy = vy; b.vz = vz; b.mass = m;
        b.bidx = 3'($urandom); b.corner = 1'($urandom);
        pending.push_back(b);
    endtask

    task automatic push_tick(input opcode_t op);
        sample_beat_t b;
        b = '0;
        b.op = op; b.id = 6'($urandom); b.px = $urandom; b.vy = $urandom;
        pending.push_back(b);
    endtask

    function automatic int pick_in(input int lo, input int hi);
        if (hi < lo)
            return lo;
        return int'(longint'(lo) + longint'($urandom_range(0, 32'(longint'(hi) - lo))));
    endfunction

    function automatic int rand_vel();
        if ($urandom_range(0, 2) == 0)
            return $urandom;
        return int'($urandom_range(0, 800000)) - 400000;
    endfunction

    task automatic push_random();
        int          r, k, c;
        int          p [3];
        logic [5:0]  id;
        logic [31:0] m;
        r = $urandom_range(0, 99);
        if (r < 72)
        begin
            id = 6'($urandom);
            for (int t = 0; t < 8 && !r_id_mask[id] && $urandom_range(0, 6) != 0; t++)
                id = 6'($urandom);
            k = $urandom_range(0, NBOX - 1);
            for (int a = 0; a < 3; a++)
                p[a] = $urandom_range(0, 4) == 0 ? int'($urandom)
                                                 : pick_in(gen_lo[k][a], gen_hi[k][a]);
            m = $urandom_range(0, 2) == 0 ? $urandom : $urandom_range(0, 400000);
            push_sample(id, p[0], p[1], p[2], rand_vel(), rand_vel(), rand_vel(), m);
        end
        else if (r < 81)
            push_tick(OP_STEP);
        else if (r < 90)
            push_tick(OP_STEP_OUT);
        else
        begin
            k = $urandom_range(0, NBOX - 1);
            c = $urandom_range(0, 1);
            for (int a = 0; a < 3; a++)
                p[a] = c ? gen_lo[k][a] + int'($urandom_range(0, 400000)) - 40000
                         : int'($urandom_range(0, 4000000)) - 2000000;
            push_load(k, c[0], p[0], p[1], p[2]);
        end
    endtask

    task automatic run_phase(input int n, input logic [3:0] bc, input logic [63:0] mask,
                             input logic [31:0] inv, input logic clr);
        set_regs(bc, mask, inv, clr);
        for (int i = 0; i < n; i++)
            push_random();
        drain();
    endtask

    initial
    begin
        int lo;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        item_ch.valid = 1'b0;
        item_ch.opcode = '0;
        item_ch.agent_id = '0;
        item_ch.pos_x = '0;
        item_ch.pos_y = '0;
        item_ch.pos_z = '0;
        item_ch.vel_x = '0;
        item_ch.vel_y = '0;
        item_ch.vel_z = '0;
        item_ch.agent_mass = '0;
        item_ch.box_index = '0;
        item_ch.corner_select = 1'b0;
        result_ch.ready = 1'b0;
        errors = 0; src_gap = 0; sink_gap = 0; hold_cnt = 0; idle_cycles = 0;
        n_items = 0; n_results = 0; n_hits = 0;
        quiet = 0; hold_go = 0; hold_done = 0; beat_in = 0;
        r_box_count = '0; r_id_mask = '0; r_inv_area = 32'd65536; r_clear = 1'b1;
        clear_sums();
        for (int k = 0; k < NBOX; k++)
            for (int a = 0; a < 3; a++)
            begin
                corner_lo[k][a] = 0; corner_hi[k][a] = 0;
            end
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // fill the whole box table before any box is in use
        for (int k = 0; k < 6; k++)
        begin
            lo = int'($urandom_range(0, 2000000)) - 1000000;
            push_load(k, 1'b0, lo, lo - 5000, lo + 7000);
            push_load(k, 1'b1, lo + 200000, lo + 150000, lo + 300000);
        end
        // start above end on x: never contains anything
        push_load(6, 1'b0, 1000, -1000, -1000);
        push_load(6, 1'b1, -1000, 1000, 1000);
        // whole coordinate range
        push_load(7, 1'b0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        push_load(7, 1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        drain();
        set_regs(4'd8, '1, 32'd65536, 1'b1);

        // edges of the fields, bounds hit exactly
        push_sample(6'd0, gen_lo[0][0], gen_lo[0][1], gen_lo[0][2],
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        push_sample(6'd63, gen_hi[0][0], gen_hi[0][1], gen_hi[0][2],
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd0);
        push_sample(6'd21, 32'h8000_0000, 32'h7FFF_FFFF, 0, -65536, 65536, 0, 32'd65536);
        push_sample(6'd42, 0, 0, 0, 0, 0, 0, 32'h8000_0000);
        push_tick(OP_STEP);
        push_tick(OP_STEP_OUT);
        push_sample(6'd7, gen_lo[6][0], 0, 0, 12345, -6789, 1, 32'd99999);
        push_sample(6'd8, gen_hi[0][0] + 1, gen_lo[0][1], gen_lo[0][2], 3, 3, 3, 32'd3);
        push_tick(OP_STEP_OUT);
        drain();

        run_phase(90, 4'd8, {$urandom, $urandom}, 32'hFFFF_FFFF, 1'b0);
        hold_go = 1;
        run_phase(90, 4'd15, '1, 32'd0, 1'b1);
        run_phase(60, 4'd0, '1, $urandom, 1'b1);
        run_phase(90, 4'd3, {$urandom, $urandom}, 32'd1, 1'b0);
        run_phase(40, 4'd8, 64'd0, $urandom, 1'b1);
        run_phase(70, 4'd1, 64'hAAAA_5555_F0F0_0F0F, $urandom, 1'b1);
        quiet = 1;
        run_phase(90, 4'd8, '1, 32'd65536, 1'b1);

        $display("covered %0d beats in, %0d averages out, %0d box hits,", n_items,
                 n_results, n_hits);
        $display("over seven register settings with stalls on both sides");
        if (errors == 0)
            $display("zone_box_property_averager_test: done, clean");
        else
            $display("zone_box_property_averager_test: done, errors");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
rtl/zbpa_pkg.sv
rtl/zbpa_if.sv
rtl/zbpa_mul.sv
rtl/zbpa_div.sv
rtl/zone_box_property_averager.sv
tb/sv/zone_box_property_averager_test.sv
